### rtl/core/lfpid_pkg.sv
// ----------------------------------------------------------------------------
// lfpid_pkg
// Types, constants and the microprogram of the line-follow PID motor drive.
// ----------------------------------------------------------------------------
package lfpid_pkg;

    localparam int POS_W   = 13;
    localparam int DIR_W   = 2;
    localparam int PWM_W   = 8;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W  = 4;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    localparam logic [15:0] LEAK_Q16    = 16'd62259;
    localparam logic [23:0] RCP5        = 24'd13421773;
    localparam int          RCP5_SHIFT  = 26;
    localparam int          BASE_SHIFT  = 36;
    localparam logic [7:0]  WHEEL_FLOOR = 8'd40;

    localparam logic [STEP_W-1:0] STEP_LOAD = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PREP = 4'd1;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP    = 3'd0,
        CFG_KI    = 3'd1,
        CFG_KD    = 3'd2,
        CFG_DB    = 3'd3,
        CFG_ILIM  = 3'd4,
        CFG_BASE  = 3'd5,
        CFG_MAX   = 3'd6,
        CFG_SLEW  = 3'd7
    } t_cfg_idx;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        A_ACC, A_DMAG, A_ERR, A_INTEG, A_DFILT, A_BFAC, A_PROD
    } t_asel;

    typedef enum logic [2:0] {
        B_LEAK, B_RCP5, B_KP, B_KI, B_KD, B_BASE, B_RCPB
    } t_bsel;

    typedef enum logic [3:0] {
        OP_LOAD, OP_PREP, OP_DSUM, OP_INTEG, OP_DFILT, OP_ACC_SET,
        OP_ACC_ADD8, OP_ACC_ADD, OP_CORR, OP_BASE, OP_CLAMP, OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        J_NEXT, J_WAIT_IN, J_WAIT_OUT, J_JUMP
    } t_jcond;

    typedef struct packed {
        t_asel             asel;
        t_bsel             bsel;
        t_op               op;
        t_jcond            jc;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        t_op   op;
        logic  fire;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_full;
    } t_cond;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [7:0]        deadband;
        logic [9:0]        ilimit;
        logic [7:0]        base;
        logic [7:0]        max_speed;
        logic [7:0]        slew;
    } t_cfg;

    typedef struct packed {
        t_dir             left_dir;
        logic [PWM_W-1:0] left_pwm;
        t_dir             right_dir;
        logic [PWM_W-1:0] right_pwm;
    } t_res;

    function automatic t_uword lfpid_ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            4'd0:    w = '{A_ACC,   B_LEAK, OP_LOAD,     J_WAIT_IN,  STEP_LOAD};
            4'd1:    w = '{A_ACC,   B_LEAK, OP_PREP,     J_NEXT,     STEP_LOAD};
            4'd2:    w = '{A_ACC,   B_LEAK, OP_DSUM,     J_NEXT,     STEP_LOAD};
            4'd3:    w = '{A_DMAG,  B_RCP5, OP_INTEG,    J_NEXT,     STEP_LOAD};
            4'd4:    w = '{A_ERR,   B_KP,   OP_DFILT,    J_NEXT,     STEP_LOAD};
            4'd5:    w = '{A_INTEG, B_KI,   OP_ACC_SET,  J_NEXT,     STEP_LOAD};
            4'd6:    w = '{A_DFILT, B_KD,   OP_ACC_ADD8, J_NEXT,     STEP_LOAD};
            4'd7:    w = '{A_BFAC,  B_BASE, OP_ACC_ADD,  J_NEXT,     STEP_LOAD};
            4'd8:    w = '{A_PROD,  B_RCPB, OP_CORR,     J_NEXT,     STEP_LOAD};
            4'd9:    w = '{A_PROD,  B_RCPB, OP_BASE,     J_NEXT,     STEP_LOAD};
            4'd10:   w = '{A_PROD,  B_RCPB, OP_CLAMP,    J_NEXT,     STEP_LOAD};
            4'd11:   w = '{A_PROD,  B_RCPB, OP_OUT,      J_WAIT_OUT, STEP_LOAD};
            default: w = '{A_PROD,  B_RCPB, OP_BASE,     J_JUMP,     STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/lfpid_in_if.sv
// ----------------------------------------------------------------------------
// lfpid_in_if
// Line-position sample channel: valid, ready and one position per beat.
// ----------------------------------------------------------------------------
interface lfpid_in_if import lfpid_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] line_position;

    modport source (output valid, output line_position, input ready);
    modport sink   (input valid, input line_position, output ready);
endinterface

### rtl/core/lfpid_out_if.sv
// ----------------------------------------------------------------------------
// lfpid_out_if
// Motor drive channel: direction and PWM of both wheels per beat.
// ----------------------------------------------------------------------------
interface lfpid_out_if import lfpid_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] left_direction;
    logic [PWM_W-1:0] left_pwm;
    logic [DIR_W-1:0] right_direction;
    logic [PWM_W-1:0] right_pwm;

    modport source (output valid, output left_direction, output left_pwm,
                    output right_direction, output right_pwm, input ready);
    modport sink   (input valid, input left_direction, input left_pwm,
                    input right_direction, input right_pwm, output ready);
endinterface

### rtl/core/lfpid_seq.sv
// ----------------------------------------------------------------------------
// lfpid_seq
// Step counter and microprogram ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module lfpid_seq import lfpid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cond i_cond,
    output t_ctrl o_ctl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;

    assign uw = lfpid_ucode(r_step);

    always_comb begin
        case (uw.jc)
            J_NEXT:     n_step = r_step + 1'b1;
            J_WAIT_IN:  n_step = i_cond.in_valid ? r_step + 1'b1 : r_step;
            J_WAIT_OUT: n_step = i_cond.out_full ? r_step : uw.target;
            J_JUMP:     n_step = uw.target;
            default:    n_step = STEP_LOAD;
        endcase
    end

    always_comb begin
        o_ctl.asel = uw.asel;
        o_ctl.bsel = uw.bsel;
        o_ctl.op   = uw.op;
        case (uw.jc)
            J_WAIT_IN:  o_ctl.fire = i_cond.in_valid;
            J_WAIT_OUT: o_ctl.fire = !i_cond.out_full;
            default:    o_ctl.fire = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_OUT)
        else $error("step counter beyond program end");

    a_accept_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_LOAD && i_cond.in_valid) |=> (r_step == STEP_PREP))
        else $error("accepted sample did not start the program");

    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_OUT && i_cond.out_full) |=> (r_step == STEP_OUT))
        else $error("result step left while output register full");

    a_out_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_OUT && !i_cond.out_full) |=> (r_step == STEP_LOAD))
        else $error("program did not return to sample load");
`endif

endmodule

### rtl/core/lfpid_dp.sv
// ----------------------------------------------------------------------------
// lfpid_dp
// Datapath: shared multiplier, accumulator and the PID and wheel state.
// ----------------------------------------------------------------------------
module lfpid_dp import lfpid_pkg::*; #(
    parameter int SENSOR_COUNT = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl            i_ctl,
    input  t_cfg             i_cfg,
    input  logic [POS_W-1:0] i_line_position,
    output t_res             o_res
);

    localparam int CENTER   = (SENSOR_COUNT - 1) * 500;
    localparam int BASE_DEN = 2 * CENTER;
    localparam logic [12:0] CENTER_V = 13'(CENTER);
    localparam logic [13:0] DEN_V    = 14'(BASE_DEN);
    localparam logic [63:0] BASE_RCP_64 =
        ((64'd1 << BASE_SHIFT) + 64'(BASE_DEN) - 64'd1) / 64'(BASE_DEN);
    localparam logic [MUL_B_W-1:0] BASE_RCP = BASE_RCP_64[MUL_B_W-1:0];

    function automatic logic [7:0] f_clamp(input logic signed [20:0] raw,
                                           input logic [7:0] top);
        logic signed [20:0] s;
        s = raw;
        if (s > $signed({13'd0, top})) s = $signed({13'd0, top});
        if (s < $signed({13'd0, WHEEL_FLOOR})) s = $signed({13'd0, WHEEL_FLOOR});
        return s[7:0];
    endfunction

    function automatic logic [7:0] f_slew(input logic [7:0] s,
                                          input logic [7:0] last,
                                          input logic [7:0] stp);
        logic [8:0] hi;
        logic [8:0] lo;
        logic [7:0] r;
        hi = {1'b0, last} + {1'b0, stp};
        lo = {1'b0, last} - {1'b0, stp};
        r  = s;
        if ({1'b0, s} > hi) r = hi[7:0];
        else if (last >= stp && {1'b0, s} < lo) r = lo[7:0];
        return r;
    endfunction

    // state
    logic signed [10:0] r_integ;
    logic signed [12:0] r_prev_err;
    logic signed [21:0] r_dfilt;
    logic [7:0]         r_prev_left;
    logic [7:0]         r_prev_right;

    // working registers
    logic signed [12:0]       r_err;
    logic [12:0]              r_mag;
    logic signed [13:0]       r_iacc;
    logic signed [13:0]       r_diff;
    logic [23:0]              r_dmag;
    logic                     r_dneg;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [39:0]       r_acc;
    logic signed [19:0]       r_corr;
    logic [7:0]               r_base;
    logic [7:0]               r_lcl;
    logic [7:0]               r_rcl;

    logic signed [13:0]        e_raw;
    logic signed [12:0]        e_sat;
    logic [12:0]               e_mag;
    logic                      e_dead;
    logic signed [24:0]        dsum;
    logic [12:0]               mcap;
    logic [13:0]               bfac;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_B_W:0]   mul_b_s;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [39:0]        prod40;
    logic signed [14:0]        i_tr;
    logic signed [14:0]        i_lim;
    logic [21:0]               dq;
    logic signed [19:0]        c_tr;
    logic signed [20:0]        l_raw;
    logic signed [20:0]        r_raw;
    logic [7:0]                l_new;
    logic [7:0]                r_new;

    always_comb begin
        e_raw = $signed({1'b0, CENTER_V}) - $signed({1'b0, i_line_position});
        if (e_raw > 14'sd4095) e_sat = 13'sd4095;
        else if (e_raw < -14'sd4096) e_sat = -13'sd4096;
        else e_sat = e_raw[12:0];
        e_mag  = e_sat[12] ? 13'(-{e_sat[12], e_sat}) : e_sat;
        e_dead = {5'd0, i_cfg.deadband} > e_mag;
    end

    assign dsum = $signed({r_diff[13], r_diff, 10'd0})
                + $signed({{3{r_dfilt[21]}}, r_dfilt});
    assign mcap = (r_mag > CENTER_V) ? CENTER_V : r_mag;
    assign bfac = DEN_V - {1'b0, mcap};

    always_comb begin
        case (i_ctl.asel)
            A_ACC:   mul_a = {{11{r_iacc[13]}}, r_iacc};
            A_DMAG:  mul_a = {1'b0, r_dmag};
            A_ERR:   mul_a = {{12{r_err[12]}}, r_err};
            A_INTEG: mul_a = {{14{r_integ[10]}}, r_integ};
            A_DFILT: mul_a = {{3{r_dfilt[21]}}, r_dfilt};
            A_BFAC:  mul_a = {11'd0, bfac};
            A_PROD:  mul_a = {2'd0, r_prod[22:0]};
            default: mul_a = '0;
        endcase
        case (i_ctl.bsel)
            B_LEAK:  mul_b = {11'd0, LEAK_Q16};
            B_RCP5:  mul_b = {3'd0, RCP5};
            B_KP:    mul_b = {11'd0, i_cfg.kp};
            B_KI:    mul_b = {11'd0, i_cfg.ki};
            B_KD:    mul_b = {11'd0, i_cfg.kd};
            B_BASE:  mul_b = {19'd0, i_cfg.base};
            B_RCPB:  mul_b = BASE_RCP;
            default: mul_b = '0;
        endcase
    end

    assign mul_b_s = $signed({1'b0, mul_b});
    assign mul_p   = mul_a * mul_b_s;
    assign prod40  = r_prod[39:0];

    // truncate toward zero
    assign i_tr  = $signed(r_prod[30:16])
                 + $signed({14'd0, r_prod[PROD_W-1] && (r_prod[15:0] != '0)});
    assign i_lim = $signed({5'd0, i_cfg.ilimit});
    assign dq    = r_prod[RCP5_SHIFT+21:RCP5_SHIFT];
    assign c_tr  = $signed(r_acc[39:20])
                 + $signed({19'd0, r_acc[39] && (r_acc[19:0] != '0)});

    assign l_raw = $signed({13'd0, r_base}) + $signed({r_corr[19], r_corr});
    assign r_raw = $signed({13'd0, r_base}) - $signed({r_corr[19], r_corr});
    assign l_new = f_slew(r_lcl, r_prev_left, i_cfg.slew);
    assign r_new = f_slew(r_rcl, r_prev_right, i_cfg.slew);

    assign o_res.left_dir  = (l_new != '0) ? DIR_FWD : DIR_STOP;
    assign o_res.left_pwm  = l_new;
    assign o_res.right_dir = (r_new != '0) ? DIR_REV : DIR_STOP;
    assign o_res.right_pwm = r_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ      <= '0;
            r_prev_err   <= '0;
            r_dfilt      <= '0;
            r_prev_left  <= '0;
            r_prev_right <= '0;
        end else begin
            case (i_ctl.op)
                OP_PREP: begin
                    r_prev_err <= r_err;
                end
                OP_INTEG: begin
                    if (i_tr > i_lim) r_integ <= i_lim[10:0];
                    else if (i_tr < -i_lim) r_integ <= 11'(-i_lim);
                    else r_integ <= i_tr[10:0];
                end
                OP_DFILT: begin
                    r_dfilt <= r_dneg ? 22'(-$signed(dq)) : $signed(dq);
                end
                OP_OUT: begin
                    if (i_ctl.fire) begin
                        r_prev_left  <= l_new;
                        r_prev_right <= r_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_ctl.op)
            OP_LOAD: begin
                r_err <= e_dead ? '0 : e_sat;
                r_mag <= e_dead ? '0 : e_mag;
            end
            OP_PREP: begin
                r_iacc <= $signed({{3{r_integ[10]}}, r_integ})
                        + $signed({r_err[12], r_err});
                r_diff <= $signed({r_err[12], r_err})
                        - $signed({r_prev_err[12], r_prev_err});
            end
            OP_DSUM: begin
                r_dneg <= dsum[24];
                r_dmag <= dsum[24] ? 24'(-dsum) : dsum[23:0];
            end
            OP_ACC_SET:  r_acc <= prod40 <<< 8;
            OP_ACC_ADD8: r_acc <= r_acc + (prod40 <<< 8);
            OP_ACC_ADD:  r_acc <= r_acc + prod40;
            OP_CORR:     r_corr <= c_tr;
            OP_BASE:     r_base <= r_prod[BASE_SHIFT+7:BASE_SHIFT];
            OP_CLAMP: begin
                r_lcl <= f_clamp(l_raw, i_cfg.max_speed);
                r_rcl <= f_clamp(r_raw, i_cfg.max_speed);
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/core/line_follow_pid_motor_drive.sv
// ----------------------------------------------------------------------------
// line_follow_pid_motor_drive
// A sample taken at the load step runs through the 12-word microprogram, which
// runs every multiply through one shared 25x28 multiplier; its last step loads
// the drive register once that has room, and only then is the next sample taken.
// The next sample is taken while the previous drive beat waits in its register.
// Reset (synchronous, active low) clears the sequencer, the integral, the
// derivative filter and the wheel history, and loads the register defaults.
// ----------------------------------------------------------------------------
module line_follow_pid_motor_drive import lfpid_pkg::*; #(
    parameter int SENSOR_COUNT = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lfpid_in_if.sink             i_line,
    lfpid_out_if.source          o_drive,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;
    t_ctrl ctl;
    t_cond cond;
    t_res  res;

    logic             r_out_valid;
    logic [DIR_W-1:0] r_out_ldir;
    logic [PWM_W-1:0] r_out_lpwm;
    logic [DIR_W-1:0] r_out_rdir;
    logic [PWM_W-1:0] r_out_rpwm;
    logic             out_load;

    assign cond.in_valid = i_line.valid;
    assign cond.out_full = r_out_valid && !o_drive.ready;
    assign i_line.ready  = (ctl.op == OP_LOAD);
    assign out_load      = (ctl.op == OP_OUT) && ctl.fire;

    lfpid_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctl   (ctl)
    );

    lfpid_dp #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_cfg           (r_cfg),
        .i_line_position (i_line.line_position),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp        <= 16'd901;
            r_cfg.ki        <= 16'd61;
            r_cfg.kd        <= 16'd8602;
            r_cfg.deadband  <= 8'd40;
            r_cfg.ilimit    <= 10'd1000;
            r_cfg.base      <= 8'd225;
            r_cfg.max_speed <= 8'd250;
            r_cfg.slew      <= 8'd40;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:   r_cfg.kp        <= i_cfg_data;
                CFG_KI:   r_cfg.ki        <= i_cfg_data;
                CFG_KD:   r_cfg.kd        <= i_cfg_data;
                CFG_DB:   r_cfg.deadband  <= i_cfg_data[7:0];
                CFG_ILIM: r_cfg.ilimit    <= i_cfg_data[9:0];
                CFG_BASE: r_cfg.base      <= i_cfg_data[7:0];
                CFG_MAX:  r_cfg.max_speed <= i_cfg_data[7:0];
                CFG_SLEW: r_cfg.slew      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_drive.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ldir <= res.left_dir;
            r_out_lpwm <= res.left_pwm;
            r_out_rdir <= res.right_dir;
            r_out_rpwm <= res.right_pwm;
        end
    end

    assign o_drive.valid           = r_out_valid;
    assign o_drive.left_direction  = r_out_ldir;
    assign o_drive.left_pwm        = r_out_lpwm;
    assign o_drive.right_direction = r_out_rdir;
    assign o_drive.right_pwm       = r_out_rpwm;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line-follow PID motor drive. A queue of line
// samples and register writes feeds a clocked driver; every sample taken is
// run through a cycle-free controller model that tracks the integral,
// derivative filter and wheel history, and the drive beats that come back
// are compared field by field in order. Both channels idle at random, the
// drive side holds off for long stretches, and registers are reprogrammed
// between phases once all drive beats are back.
// ----------------------------------------------------------------------------
module tb_top import lfpid_pkg::*; ();

    localparam int     SENSOR_COUNT = 6;
    localparam longint CENTER       = (SENSOR_COUNT - 1) * 500;
    localparam int     PHASES       = 12;
    localparam int     PHASE_BEATS  = 165;
    localparam int     STALL_LIMIT  = 3000;
    localparam int     SETTLE_CYC   = 40;

    typedef enum logic [1:0] {PEND_SAMPLE, PEND_CFG, PEND_DRAIN} t_pend_kind;

    typedef struct packed {
        t_pend_kind        kind;
        logic [POS_W-1:0]  pos;
        t_cfg_idx          idx;
        logic [CFG_W-1:0]  data;
    } t_pend;

    logic             clk    = 1'b0;
    logic             rst_n  = 1'b0;
    logic             cfg_we = 1'b0;
    t_cfg_idx         cfg_index = CFG_KP;
    logic [CFG_W-1:0] cfg_data  = '0;

    lfpid_in_if  line_if ();
    lfpid_out_if drive_if ();

    line_follow_pid_motor_drive #(.SENSOR_COUNT(SENSOR_COUNT)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_line      (line_if),
        .o_drive     (drive_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    t_pend  pend_q[$];
    t_res   drive_expq[$];
    int     mismatch_count = 0;
    int     idle_cycles    = 0;
    int     drives_seen    = 0;

    int pos_list[11] = '{2500, 0, 5000, 8191, 6596, 6597, 2539, 2540, 2461, 2460, 4096};

    longint ctl_kp, ctl_ki, ctl_kd, ctl_deadband, ctl_ilimit;
    longint ctl_base, ctl_max, ctl_slew;
    longint ctl_integ, ctl_prev_err, ctl_dfilt, ctl_prev_left, ctl_prev_right;

    initial forever #5 clk = ~clk;

    function automatic logic [CFG_W-1:0] cfg_limit(input t_cfg_idx ci);
        case (ci)
            CFG_KP, CFG_KI, CFG_KD: return 16'd65535;
            CFG_ILIM:               return 16'd1023;
            default:                return 16'd255;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] cfg_default(input t_cfg_idx ci);
        case (ci)
            CFG_KP:   return 16'd901;
            CFG_KI:   return 16'd61;
            CFG_KD:   return 16'd8602;
            CFG_DB:   return 16'd40;
            CFG_ILIM: return 16'd1000;
            CFG_BASE: return 16'd225;
            CFG_MAX:  return 16'd250;
            default:  return 16'd40;
        endcase
    endfunction

    function automatic void write_model_reg(input t_cfg_idx ci, input logic [CFG_W-1:0] v);
        case (ci)
            CFG_KP:   ctl_kp       = v;
            CFG_KI:   ctl_ki       = v;
            CFG_KD:   ctl_kd       = v;
            CFG_DB:   ctl_deadband = v[7:0];
            CFG_ILIM: ctl_ilimit   = v[9:0];
            CFG_BASE: ctl_base     = v[7:0];
            CFG_MAX:  ctl_max      = v[7:0];
            CFG_SLEW: ctl_slew     = v[7:0];
            default: begin
            end
        endcase
    endfunction

    function automatic longint limit_wheel(input longint raw, input longint last);
        longint s;
        s = raw;
        if (s > ctl_max) s = ctl_max;
        if (s < longint'(WHEEL_FLOOR)) s = longint'(WHEEL_FLOOR);
        if (s > last + ctl_slew) s = last + ctl_slew;
        if (s < last - ctl_slew) s = last - ctl_slew;
        return s;
    endfunction

    function automatic t_res predict_drive(input logic [POS_W-1:0] pos);
        longint err, mag, acc, d, corr, base, left, right;
        t_res   r;
        err = CENTER - longint'(pos);
        if (err > 4095) err = 4095;
        if (err < -4096) err = -4096;
        mag = (err < 0) ? -err : err;
        if (mag < ctl_deadband) begin
            err = 0;
            mag = 0;
        end
        acc = (ctl_integ + err) * longint'(LEAK_Q16) / 65536;
        if (acc > ctl_ilimit) acc = ctl_ilimit;
        if (acc < -ctl_ilimit) acc = -ctl_ilimit;
        ctl_integ = acc;
        d = err - ctl_prev_err;
        ctl_prev_err = err;
        ctl_dfilt = (d * 1024 + ctl_dfilt) / 5;
        corr = (err * ctl_kp * 256 + ctl_integ * ctl_ki * 256 + ctl_dfilt * ctl_kd)
             / 1048576;
        if (mag > CENTER) mag = CENTER;
        base = ctl_base * (2 * CENTER - mag) / (2 * CENTER);
        left  = limit_wheel(base + corr, ctl_prev_left);
        right = limit_wheel(base - corr, ctl_prev_right);
        ctl_prev_left  = left;
        ctl_prev_right = right;
        r.left_dir  = (left > 0) ? DIR_FWD : DIR_STOP;
        r.left_pwm  = left[PWM_W-1:0];
        r.right_dir = (right > 0) ? DIR_REV : DIR_STOP;
        r.right_pwm = right[PWM_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    function automatic void add_sample(input int pos);
        t_pend p;
        p = '0;
        p.kind = PEND_SAMPLE;
        p.pos  = pos[POS_W-1:0];
        pend_q.push_back(p);
    endfunction

    function automatic void add_cfg(input t_cfg_idx ci, input logic [CFG_W-1:0] v);
        t_pend p;
        p = '0;
        p.kind = PEND_CFG;
        p.idx  = ci;
        p.data = v;
        pend_q.push_back(p);
    endfunction

    // sample driver
    always @(posedge clk) begin : sample_driver
        t_pend head;
        logic  take, nxt_valid, nxt_we;
        int    send_gap, calm_beats;
        take = line_if.valid && line_if.ready;
        if (!rst_n) begin
            line_if.valid <= 1'b0;
            cfg_we        <= 1'b0;
            send_gap   = 0;
            calm_beats = 0;
        end else begin
            if (take) begin
                drive_expq.push_back(predict_drive(line_if.line_position));
                if (calm_beats > 0) begin
                    calm_beats--;
                    send_gap = 0;
                end else begin
                    send_gap = pick_gap();
                    if ($urandom_range(0, 99) == 0) calm_beats = 40;
                end
            end
            nxt_valid = line_if.valid && !take;
            nxt_we    = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() != 0) begin
                    head = pend_q[0];
                    case (head.kind)
                        PEND_SAMPLE: begin
                            nxt_valid = 1'b1;
                            line_if.line_position <= head.pos;
                            void'(pend_q.pop_front());
                        end
                        PEND_CFG: begin
                            if (!line_if.valid && drive_expq.size() == 0) begin
                                nxt_we = 1'b1;
                                cfg_index <= head.idx;
                                cfg_data  <= head.data;
                                write_model_reg(head.idx, head.data);
                                void'(pend_q.pop_front());
                            end
                        end
                        default: begin
                            if (drive_expq.size() == 0) void'(pend_q.pop_front());
                        end
                    endcase
                end
            end
            line_if.valid <= nxt_valid;
            cfg_we        <= nxt_we;
        end
    end

    // drive monitor and ready pacing
    always @(posedge clk) begin : drive_monitor
        t_res want;
        logic nxt_ready;
        int   stall_cnt, hold_cnt, calm_cycles;
        if (!rst_n) begin
            drive_if.ready <= 1'b0;
            stall_cnt   = 0;
            hold_cnt    = 0;
            calm_cycles = 0;
        end else begin
            if (drive_if.valid && drive_if.ready) begin
                drives_seen++;
                if (drive_expq.size() == 0) begin
                    $display("%0t: unexpected drive beat: left %0d/%0d right %0d/%0d",
                             $time, drive_if.left_direction, drive_if.left_pwm,
                             drive_if.right_direction, drive_if.right_pwm);
                    mismatch_count++;
                end else begin
                    want = drive_expq.pop_front();
                    check_field("left_direction", 8'(want.left_dir),
                                8'(drive_if.left_direction));
                    check_field("left_pwm", want.left_pwm, drive_if.left_pwm);
                    check_field("right_direction", 8'(want.right_dir),
                                8'(drive_if.right_direction));
                    check_field("right_pwm", want.right_pwm, drive_if.right_pwm);
                end
                if (drives_seen == 150 || drives_seen == 1300) hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                nxt_ready = 1'b0;
            end else if (calm_cycles > 0) begin
                calm_cycles--;
                nxt_ready = 1'b1;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_cnt = pick_gap();
                if ($urandom_range(0, 299) == 0) calm_cycles = 150;
            end
            drive_if.ready <= nxt_ready;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (line_if.valid && line_if.ready) ||
            (drive_if.valid && drive_if.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_cfg_idx   ci;
        int         walk, r, pos;
        logic [CFG_W-1:0] val;

        line_if.valid         = 1'b0;
        line_if.line_position = '0;
        drive_if.ready        = 1'b0;
        ctl_integ = 0; ctl_prev_err = 0; ctl_dfilt = 0;
        ctl_prev_left = 0; ctl_prev_right = 0;
        ci = ci.first();
        do begin
            write_model_reg(ci, cfg_default(ci));
            ci = ci.next();
        end while (ci != ci.first());

        // zero slew from a standing start: both wheels stop
        add_cfg(CFG_SLEW, 16'd0);
        add_sample(2500);
        add_sample(0);
        // small slew: speeds creep up below the floor
        add_cfg(CFG_SLEW, 16'd15);
        add_sample(8191);
        add_sample(5000);
        // default slew: center, extremes, saturation and deadband edges
        add_cfg(CFG_SLEW, cfg_default(CFG_SLEW));
        foreach (pos_list[i]) add_sample(pos_list[i]);
        // gains off, max below floor
        add_cfg(CFG_KP, 16'd0);
        add_cfg(CFG_KI, 16'd0);
        add_cfg(CFG_KD, 16'd0);
        add_cfg(CFG_ILIM, 16'd0);
        add_cfg(CFG_MAX, 16'd10);
        add_cfg(CFG_SLEW, 16'd255);
        add_cfg(CFG_BASE, 16'd255);
        add_sample(0);
        add_sample(2500);
        add_sample(8191);

        walk = 2500;
        for (int p = 0; p < PHASES; p++) begin
            ci = ci.first();
            do begin
                case (p)
                    0: val = cfg_limit(ci);
                    1: val = '0;
                    2: val = cfg_default(ci);
                    default: begin
                        r = $urandom_range(0, 9);
                        if (r == 0)      val = '0;
                        else if (r == 1) val = cfg_limit(ci);
                        else if (r < 5)  val = cfg_default(ci);
                        else if (r < 7)  val = $urandom_range(0, cfg_limit(ci));
                        else             val = $urandom_range(0, cfg_limit(ci) / 16);
                    end
                endcase
                add_cfg(ci, val);
                ci = ci.next();
            end while (ci != ci.first());
            for (int n = 0; n < PHASE_BEATS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    walk += int'($urandom_range(0, 600)) - 300;
                    if (walk < 0) walk = 0;
                    if (walk > 5000) walk = 5000;
                    pos = walk;
                end else if (r < 85) begin
                    pos = $urandom_range(0, 8191);
                end else begin
                    pos = 2440 + int'($urandom_range(0, 120));
                end
                add_sample(pos);
                if (p == 5 && n == 80) begin
                    pend_q.push_back(t_pend'{kind: PEND_DRAIN, pos: '0, idx: CFG_KP,
                                             data: '0});
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || line_if.valid || drive_expq.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
